// ===== rtl/stable_priority_queue_unit_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Condition that must hold at every edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("spq check failed");

// Antecedent implies consequent at the next edge.
`define SPQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed");

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 32;
  localparam int RANK_W   = 6;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int ECNT_W   = 5;

  localparam int IN_DATA_BITS  = RANK_W + TAG_BITS;
  localparam int IN_TDATA_W    = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 1 + TAG_BITS + RANK_W + 1 + 1 + ECNT_W;
  localparam int OUT_TDATA_W   = ((OUT_DATA_BITS + 7) / 8) * 8;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic load;
    logic push;
    logic pop;
    logic refuse;
    logic empty_pop;
  } spq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } spq_status_t;

  typedef struct packed {
    logic [ECNT_W-1:0]        entry_count;
    logic                     was_empty;
    logic                     push_refused;
    logic signed [RANK_W-1:0] out_rank;
    logic [TAG_BITS-1:0]      out_tag;
    logic                     out_valid;
  } spq_result_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_op,
  input  logic        out_tready,
  input  spq_status_t status,
  output logic        in_tready,
  output logic        out_tvalid,
  output spq_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_HOLD = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_tready  = (state_r == ST_IDLE) || out_tready;
  assign out_tvalid = (state_r == ST_HOLD);
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    cmd.load      = accept;
    cmd.push      = accept && (in_op == OP_PUSH) && !status.full;
    cmd.refuse    = accept && (in_op == OP_PUSH) && status.full;
    cmd.pop       = accept && (in_op == OP_POP) && !status.empty;
    cmd.empty_pop = accept && (in_op == OP_POP) && status.empty;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_nxt = ST_HOLD;
        else if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/spq_datapath.sv =====
module spq_datapath
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_cmd_t                 cmd,
  input  logic signed [RANK_W-1:0] in_rank,
  input  logic [TAG_BITS-1:0]      in_tag,
  output spq_status_t              status,
  output spq_result_t              result
);

  logic signed [RANK_W-1:0] rank_r   [DEPTH];
  logic signed [RANK_W-1:0] rank_nxt [DEPTH];
  logic [TAG_BITS-1:0]      tag_r    [DEPTH];
  logic [TAG_BITS-1:0]      tag_nxt  [DEPTH];
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [DEPTH-1:0]         stay;
  spq_result_t              result_r;
  spq_result_t              result_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign result       = result_r;

  // cells holding an entry that outranks or ties the new one keep it
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      stay[i] = (CNT_W'(i) < count_r) && (rank_r[i] >= in_rank);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rank_nxt[i] = rank_r[i];
      tag_nxt[i]  = tag_r[i];
    end
    if (cmd.push) begin
      if (!stay[0]) begin
        rank_nxt[0] = in_rank;
        tag_nxt[0]  = in_tag;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!stay[i]) begin
          if (stay[i-1]) begin
            rank_nxt[i] = in_rank;
            tag_nxt[i]  = in_tag;
          end else begin
            rank_nxt[i] = rank_r[i-1];
            tag_nxt[i]  = tag_r[i-1];
          end
        end
      end
    end else if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        rank_nxt[i] = rank_r[i+1];
        tag_nxt[i]  = tag_r[i+1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.push) count_nxt = count_r + CNT_W'(1);
    else if (cmd.pop) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    result_nxt.out_valid    = cmd.pop;
    result_nxt.out_tag      = cmd.pop ? tag_r[0] : '0;
    result_nxt.out_rank     = cmd.pop ? rank_r[0] : '0;
    result_nxt.push_refused = cmd.refuse;
    result_nxt.was_empty    = cmd.empty_pop;
    result_nxt.entry_count  = ECNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      rank_r[i] <= rank_nxt[i];
      tag_r[i]  <= tag_nxt[i];
    end
    if (cmd.load) result_r <= result_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/stable_priority_queue_unit.sv =====
// Stable bounded priority queue, up to 16 entries of signed rank and 32-bit tag.
// Input channel in_*: in_tuser is the operation (0 push, 1 pop); in_tdata
// carries the rank and tag of a push. Every input beat yields exactly one
// result beat on out_*: the popped entry or flags for a refused push or an
// empty pop, plus the entry count after the operation.
// Highest rank leaves first; equal ranks leave in arrival order.
// Latency: the result beat is presented the cycle after the input beat.
// Throughput: one beat per cycle; the insert compares every slot of the
// sorted register chain in parallel and shifts the tail combinationally.
// The single output register is refilled in the same cycle it is drained.
// Receiver stall: with a result held and out_tready low, in_tready drops
// and the queue holds still until the result is taken.
// Reset (rst_n low, synchronous): queue empties, no result is held.
module stable_priority_queue_unit
  import spq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // item_rank[5:0], item_tag[37:6], zero pad
  input  logic                   in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // out_valid[0], out_tag[32:1],
                                             // out_rank[38:33], push_refused[39],
                                             // was_empty[40], entry_count[45:41],
                                             // zero pad
);

  spq_cmd_t    cmd;
  spq_status_t status;
  spq_result_t result;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .out_tready (out_tready),
    .status     (status),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  spq_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_rank (in_tdata[RANK_W-1:0]),
    .in_tag  (in_tdata[RANK_W +: TAG_BITS]),
    .status  (status),
    .result  (result)
  );

  assign out_tdata = OUT_TDATA_W'(result);

endmodule

// ===== rtl/spq_checker.sv =====
`include "stable_priority_queue_unit_macros.svh"

module spq_checker
  import spq_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic             res_valid;
  logic             res_refused;
  logic             res_empty;
  logic [ECNT_W-1:0] res_count;

  assign res_valid   = out_tdata[0];
  assign res_refused = out_tdata[TAG_BITS + RANK_W + 1];
  assign res_empty   = out_tdata[TAG_BITS + RANK_W + 2];
  assign res_count   = out_tdata[TAG_BITS + RANK_W + 3 +: ECNT_W];

  `SPQ_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid)
  `SPQ_ASSERT_NEXT(a_beat_yields_result, in_tvalid && in_tready, out_tvalid)
  `SPQ_ASSERT_ALWAYS(a_one_outcome, !out_tvalid || $onehot0({res_valid, res_refused, res_empty}))
  `SPQ_ASSERT_ALWAYS(a_empty_count, !(out_tvalid && res_empty) || (res_count == '0))
  `SPQ_ASSERT_ALWAYS(a_refused_full, !(out_tvalid && res_refused) || (res_count == ECNT_W'(DEPTH)))

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
